[src/bfbpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbpa_pkg
// Shared types and constants of the best-fit block pool allocator.
// ----------------------------------------------------------------------------
package bfbpa_pkg;

   localparam int SIZE_W      = 10;
   localparam int CNT_W       = 6;
   localparam int OFF_W       = 10;
   localparam int NCLS_W      = 2;
   localparam int CLASS_SLOTS = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_CLASSES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS0_SIZE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS0_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS1_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS1_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS2_SIZE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS2_COUNT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] NUM_REGS         = 3'd7;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SIZE_W-1:0] request_size;
      logic [OFF_W-1:0]  free_offset;
   } cmd_type;

   typedef struct packed {
      logic [NCLS_W-1:0]                  num_classes;
      logic [CLASS_SLOTS-1:0][SIZE_W-1:0] size;
      logic [CLASS_SLOTS-1:0][CNT_W-1:0]  count;
   } cfg_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic commit;
      logic used_any;
   } back_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } back_state_type;

endpackage

[src/best_fit_block_pool_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_pool_allocator_unit
// Fixed-block pool allocator with best-fit allocation and free by offset.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  req_*    | in        | tuser: action; tdata: request_size [9:0], free_offset [19:10]
//  rsp_*    | out       | tuser: ok; tdata: data_offset [9:0]
//  csr_*    | in        | write enable, register index, write data
//
//  For each item the back scan walks B blocks (fewer for a free that matches early)
//  and steps over C class boundaries.
//  The scan sequencer visits one block per cycle; that loop sets the rate.
//  Reset clears the used marks, the registers and all handshake state at once.
//  Requests queue in front while the scan runs; a held result stalls the back.
// ----------------------------------------------------------------------------
module best_fit_block_pool_allocator_unit #(
   parameter int POOL_BYTES   = 1024,
   parameter int HEADER_BYTES = 12,
   parameter int MAX_BLOCKS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bfbpa_pkg::REQ_TDATA_W-1:0]   req_tdata,   // request_size, free_offset
   input  logic                                req_tuser,   // action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bfbpa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // data_offset
   output logic                                rsp_tuser,   // ok
   input  logic                                csr_we,
   input  logic [bfbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfbpa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bfbpa_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             cfg_clear;
   logic             f_valid, f_ready;
   cmd_type          f_cmd;
   logic             q_valid, q_pop;
   cmd_type          q_cmd;
   queue_status_type q_status;
   back_status_type  b_status;

   assign cfg_clear = csr_we && (csr_index < NUM_REGS);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_NUM_CLASSES:  cfg_in.num_classes = csr_wdata[NCLS_W-1:0];
            REG_CLASS0_SIZE:  cfg_in.size[0]     = csr_wdata[SIZE_W-1:0];
            REG_CLASS0_COUNT: cfg_in.count[0]    = csr_wdata[CNT_W-1:0];
            REG_CLASS1_SIZE:  cfg_in.size[1]     = csr_wdata[SIZE_W-1:0];
            REG_CLASS1_COUNT: cfg_in.count[1]    = csr_wdata[CNT_W-1:0];
            REG_CLASS2_SIZE:  cfg_in.size[2]     = csr_wdata[SIZE_W-1:0];
            REG_CLASS2_COUNT: cfg_in.count[2]    = csr_wdata[CNT_W-1:0];
            default:          cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bfbpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   bfbpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_cmd   (f_cmd),
      .push_ready (f_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .status     (q_status)
   );

   bfbpa_back #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cfg_clear  (cfg_clear),
      .cmd_valid  (q_valid),
      .cmd        (q_cmd),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .status     (b_status)
   );

   a_cfg_clears_used: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> !b_status.used_any)
      else $error("used marks survive a register write");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overflow");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(b_status.commit))
      else $error("result raised without a commit");

   a_fail_zero_offset: assert property (@(posedge clock) disable iff (reset)
      b_status.commit |=> (rsp_tuser || rsp_tdata == '0))
      else $error("failed transaction carries an offset");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !b_status.busy)
      else $error("command popped while the back is busy");

endmodule

[src/bfbpa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbpa_front
// Accepts request transactions, decodes the operation and holds the command
// until the queue takes it.
// ----------------------------------------------------------------------------
module bfbpa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bfbpa_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                req_tuser,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output bfbpa_pkg::cmd_type                  cmd
);
   import bfbpa_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req_tready = !valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (valid_ff && cmd_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in            = 1'b1;
         cmd_in.op           = req_tuser ? OP_FREE : OP_ALLOC;
         cmd_in.request_size = req_tdata[SIZE_W-1:0];
         cmd_in.free_offset  = req_tdata[SIZE_W+OFF_W-1:SIZE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

[src/bfbpa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbpa_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module bfbpa_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  bfbpa_pkg::cmd_type             push_cmd,
   output logic                           push_ready,
   input  logic                           pop,
   output logic                           pop_valid,
   output bfbpa_pkg::cmd_type             pop_cmd,
   output bfbpa_pkg::queue_status_type    status
);
   import bfbpa_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign status.count = cnt_ff;

endmodule

[src/bfbpa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbpa_back
// Walks the carved pool one block per cycle, picks the best-fit free block or
// the matching block to free, updates the used marks and registers the result.
// ----------------------------------------------------------------------------
module bfbpa_back #(
   parameter int POOL_BYTES   = 1024,
   parameter int HEADER_BYTES = 12,
   parameter int MAX_BLOCKS   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bfbpa_pkg::cfg_type                  cfg,
   input  logic                                cfg_clear,
   input  logic                                cmd_valid,
   input  bfbpa_pkg::cmd_type                  cmd,
   output logic                                cmd_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bfbpa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                rsp_tuser,
   output bfbpa_pkg::back_status_type          status
);
   import bfbpa_pkg::*;

   localparam int POS_W = $clog2(POOL_BYTES + HEADER_BYTES + (1 << SIZE_W)) + 1;
   localparam int K_W   = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [NCLS_W-1:0]  cls_ff, cls_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [SIZE_W-1:0]  best_size_ff, best_size_in;
   logic [POS_W-1:0]   best_data_ff, best_data_in;
   logic [MAX_BLOCKS-1:0] used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [OFF_W-1:0]   rsp_off_ff, rsp_off_in;

   logic [SIZE_W-1:0]  cur_size;
   logic [CNT_W-1:0]   cur_count;
   logic [POS_W-1:0]   blk_data;
   logic [POS_W-1:0]   blk_end;
   logic [IDX_W-1:0]   idx;
   logic               fits, k_room, cand_alloc, match_free;

   always_comb begin
      unique case (cls_ff)
         2'd0: begin
            cur_size  = cfg.size[0];
            cur_count = cfg.count[0];
         end
         2'd1: begin
            cur_size  = cfg.size[1];
            cur_count = cfg.count[1];
         end
         2'd2: begin
            cur_size  = cfg.size[2];
            cur_count = cfg.count[2];
         end
         default: begin
            cur_size  = '0;
            cur_count = '0;
         end
      endcase
   end

   assign idx      = k_ff[IDX_W-1:0];
   assign blk_data = pos_ff + POS_W'(HEADER_BYTES);
   assign blk_end  = blk_data + POS_W'(cur_size);
   assign fits     = blk_end <= POS_W'(POOL_BYTES);
   assign k_room   = k_ff < K_W'(MAX_BLOCKS);

   assign cand_alloc = (cmd_ff.op == OP_ALLOC) && !used_ff[idx]
                       && (cur_size >= cmd_ff.request_size)
                       && (!found_ff || (cur_size <= best_size_ff));
   assign match_free = (cmd_ff.op == OP_FREE)
                       && (POS_W'(cmd_ff.free_offset) == blk_data);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cls_in       = cls_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_size_in = best_size_ff;
      best_data_in = best_data_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_off_in   = rsp_off_ff;
      cmd_pop      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               cls_in   = '0;
               j_in     = '0;
               pos_in   = '0;
               k_in     = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cls_ff >= cfg.num_classes) begin
               state_in = ST_COMMIT;
            end else if (j_ff >= cur_count) begin
               cls_in = cls_ff + 1'b1;
               j_in   = '0;
            end else if (!k_room || !fits) begin
               state_in = ST_COMMIT;
            end else begin
               if (cand_alloc || match_free) begin
                  found_in     = 1'b1;
                  best_in      = idx;
                  best_size_in = cur_size;
                  best_data_in = blk_data;
               end
               if (match_free) begin
                  state_in = ST_COMMIT;
               end
               pos_in = blk_end;
               k_in   = k_ff + 1'b1;
               j_in   = j_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = found_ff;
               rsp_off_in   = (found_ff && cmd_ff.op == OP_ALLOC)
                              ? best_data_ff[OFF_W-1:0] : '0;
               if (found_ff) begin
                  used_in[best_ff] = (cmd_ff.op == OP_ALLOC);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any register write re-carves the pool
      if (cfg_clear) begin
         used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cls_ff       <= cls_in;
      j_ff         <= j_in;
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_size_ff <= best_size_in;
      best_data_ff <= best_data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_off_ff   <= rsp_off_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-OFF_W){1'b0}}, rsp_off_ff};

   assign status.busy     = state_ff != ST_IDLE;
   assign status.commit   = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);
   assign status.used_any = |used_ff;

endmodule

[tb/sv/best_fit_block_pool_allocator_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_pool_allocator_unit_test
// Self-checking bench for the best-fit block pool allocator. A tracker class
// keeps its own copy of the class registers, the carved block layout and the
// used marks. It predicts the grant or release of every request the block
// takes and matches each response against it in order. A short directed set
// covers exact fits, headers past the pool end, capped counts and
// already-free blocks. Random pool layouts follow with allocate/free traffic,
// random idling on both channels, one long response stall and a final calm
// stretch with no idling.
// ----------------------------------------------------------------------------
module best_fit_block_pool_allocator_unit_test;
   import bfbpa_pkg::*;

   localparam int POOL_BYTES   = 1024;
   localparam int HEADER_BYTES = 12;
   localparam int MAX_BLOCKS   = 32;
   localparam int SETTLE       = MAX_BLOCKS + 8;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic             ok;
      logic [OFF_W-1:0] offset;
   } grant_type;

   class pool_tracker;
      logic [NCLS_W-1:0] num_classes;
      logic [SIZE_W-1:0] cls_size[CLASS_SLOTS];
      logic [CNT_W-1:0]  cls_count[CLASS_SLOTS];
      bit                in_use[MAX_BLOCKS];
      int                blk_off[MAX_BLOCKS];
      int                blk_len[MAX_BLOCKS];
      int                nblocks;
      grant_type         awaited[$];
      int                errors;
      int                n_granted, n_refused, n_released, n_unmatched;

      function new();
         num_classes = '0;
         foreach (cls_size[c]) begin
            cls_size[c]  = '0;
            cls_count[c] = '0;
         end
         foreach (in_use[k]) in_use[k] = 1'b0;
         nblocks = 0;
      endfunction

      function void carve();
         int pos;
         pos = 0;
         nblocks = 0;
         for (int c = 0; c < num_classes; c++)
            for (int j = 0; j < cls_count[c]; j++) begin
               if (nblocks >= MAX_BLOCKS || pos + HEADER_BYTES + cls_size[c] > POOL_BYTES)
                  return;
               blk_off[nblocks] = pos + HEADER_BYTES;
               blk_len[nblocks] = cls_size[c];
               pos += HEADER_BYTES + cls_size[c];
               nblocks++;
            end
      endfunction

      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_NUM_CLASSES:  num_classes  = val[NCLS_W-1:0];
            REG_CLASS0_SIZE:  cls_size[0]  = val[SIZE_W-1:0];
            REG_CLASS0_COUNT: cls_count[0] = val[CNT_W-1:0];
            REG_CLASS1_SIZE:  cls_size[1]  = val[SIZE_W-1:0];
            REG_CLASS1_COUNT: cls_count[1] = val[CNT_W-1:0];
            REG_CLASS2_SIZE:  cls_size[2]  = val[SIZE_W-1:0];
            REG_CLASS2_COUNT: cls_count[2] = val[CNT_W-1:0];
            default:          return;
         endcase
         foreach (in_use[k]) in_use[k] = 1'b0;
         carve();
      endfunction

      function void take_request(op_type op, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
         grant_type g;
         bit        found;
         int        best;
         g = '0;
         found = 1'b0;
         best = 0;
         if (op == OP_ALLOC) begin
            for (int k = 0; k < nblocks; k++)
               if (!in_use[k] && blk_len[k] >= size && (!found || blk_len[k] <= blk_len[best])) begin
                  best = k;
                  found = 1'b1;
               end
            if (found) begin
               in_use[best] = 1'b1;
               g.ok = 1'b1;
               g.offset = OFF_W'(blk_off[best]);
               n_granted++;
            end else
               n_refused++;
         end else begin
            for (int k = 0; k < nblocks; k++)
               if (blk_off[k] == off) begin
                  in_use[k] = 1'b0;
                  g.ok = 1'b1;
                  found = 1'b1;
                  break;
               end
            if (found) n_released++;
            else n_unmatched++;
         end
         awaited.push_back(g);
      endfunction

      function void match_response(logic ok, logic [OFF_W-1:0] off);
         grant_type g;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected response ok=%0b offset=%0d", $time, ok, off);
            return;
         end
         g = awaited.pop_front();
         if (ok !== g.ok || off !== g.offset) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch: expected ok=%0b offset=%0d, got ok=%0b offset=%0d",
                        $time, g.ok, g.offset, ok, off);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // request_size, free_offset
   logic                   req_tuser;   // action
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // data_offset
   logic                   rsp_tuser;   // ok
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pool_tracker sb = new();
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;
   int          gap_pct = 0;
   int          n_layouts = 0;

   best_fit_block_pool_allocator_unit #(
      .POOL_BYTES  (POOL_BYTES),
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_BLOCKS  (MAX_BLOCKS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_response(rsp_tuser, rsp_tdata[OFF_W-1:0]);

   // response side: random stalls, one long hold on request, always ready when calm
   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic offer(op_type op, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({off, size});
      do @(posedge clock); while (!req_tready);
      sb.take_request(op, size, off);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.apply_write(idx, val);
   endtask

   task automatic setup_pool(logic [CSR_DATA_W-1:0] ncls,
                             logic [CSR_DATA_W-1:0] s0, logic [CSR_DATA_W-1:0] c0,
                             logic [CSR_DATA_W-1:0] s1, logic [CSR_DATA_W-1:0] c1,
                             logic [CSR_DATA_W-1:0] s2, logic [CSR_DATA_W-1:0] c2);
      drain();
      write_reg(REG_NUM_CLASSES, ncls);
      write_reg(REG_CLASS0_SIZE, s0);
      write_reg(REG_CLASS0_COUNT, c0);
      write_reg(REG_CLASS1_SIZE, s1);
      write_reg(REG_CLASS1_COUNT, c1);
      write_reg(REG_CLASS2_SIZE, s2);
      write_reg(REG_CLASS2_COUNT, c2);
      csr_we <= 1'b0;
      @(posedge clock);
      n_layouts++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CSR_DATA_W'($urandom_range(0, 40));
      if (r < 85) return CSR_DATA_W'($urandom_range(41, 200));
      return CSR_DATA_W'($urandom_range(0, 1023));
   endfunction

   // upper write bits beyond the count width are random and must be dropped
   function automatic logic [CSR_DATA_W-1:0] pick_count();
      int r;
      logic [CNT_W-1:0] n;
      r = $urandom_range(0, 99);
      if (r < 70) n = CNT_W'($urandom_range(0, 10));
      else if (r < 90) n = CNT_W'($urandom_range(11, 32));
      else n = CNT_W'($urandom_range(33, 63));
      return {4'($urandom_range(0, 15)), n};
   endfunction

   task automatic random_layout();
      logic [CSR_DATA_W-1:0] ncls;
      ncls = {8'($urandom_range(0, 255)),
              ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3))};
      setup_pool(ncls, pick_size(), pick_count(), pick_size(), pick_count(),
                 pick_size(), pick_count());
   endtask

   task automatic random_item();
      op_type            op;
      logic [SIZE_W-1:0] size;
      logic [OFF_W-1:0]  off;
      int                k;
      int                d;
      op   = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
      size = SIZE_W'($urandom_range(0, 1023));
      off  = OFF_W'($urandom_range(0, 1023));
      if (op == OP_ALLOC && $urandom_range(0, 9) < 7) begin
         k = $urandom_range(0, CLASS_SLOTS - 1);
         d = $urandom_range(0, 3);
         size = (sb.cls_size[k] < d) ? '0 : SIZE_W'(sb.cls_size[k] - d);
      end
      if (op == OP_FREE && sb.nblocks > 0 && $urandom_range(0, 3) != 0)
         off = OFF_W'(sb.blk_off[$urandom_range(0, sb.nblocks - 1)]);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      offer(op, size, off);
   endtask

   function automatic logic [OFF_W-1:0] junk();
      return OFF_W'($urandom_range(0, 1023));
   endfunction

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no blocks after reset
      offer(OP_ALLOC, '0, junk());
      offer(OP_FREE, junk(), '0);

      // full-size block, then a zero-size block whose data sits at the pool end
      setup_pool(10'h3FF, 10'd1000, 10'd1, 10'd0, 10'd2, 10'd5, 10'd3);
      offer(OP_ALLOC, 10'd0, junk());
      offer(OP_ALLOC, 10'd0, junk());
      offer(OP_ALLOC, 10'd1, junk());
      offer(OP_FREE, junk(), 10'd12);
      offer(OP_FREE, junk(), 10'd0);
      offer(OP_FREE, junk(), 10'd1023);
      offer(OP_ALLOC, 10'd1000, junk());
      offer(OP_ALLOC, 10'd1023, junk());

      // exact fit; oversize classes dropped; write to an unmapped index
      setup_pool(10'd3, 10'd1012, 10'd1, 10'd1023, 10'h3FF, 10'd1023, 10'd63);
      offer(OP_ALLOC, 10'd1013, junk());
      offer(OP_ALLOC, 10'd1012, junk());
      drain();
      write_reg(NUM_REGS, 10'h3FF);
      csr_we <= 1'b0;
      @(posedge clock);
      offer(OP_ALLOC, 10'd1012, junk());
      offer(OP_FREE, junk(), 10'd12);
      offer(OP_FREE, junk(), 10'd12);

      // zero-size blocks capped at the block limit; ties go to the last one
      setup_pool(10'd3, 10'd0, 10'h3FF, 10'd0, 10'd63, 10'd0, 10'd63);
      offer(OP_ALLOC, 10'd0, junk());
      offer(OP_ALLOC, 10'd0, junk());
      offer(OP_ALLOC, 10'd0, junk());
      offer(OP_FREE, junk(), 10'd384);
      offer(OP_ALLOC, 10'd0, junk());

      // best fit across two classes, third class configured but unused
      setup_pool(10'd2, 10'd16, 10'd4, 10'd8, 10'd4, 10'd4, 10'd4);
      offer(OP_ALLOC, 10'd5, junk());
      offer(OP_ALLOC, 10'd9, junk());
      offer(OP_ALLOC, 10'd17, junk());
      offer(OP_ALLOC, 10'd4, junk());

      for (int phase = 0; phase < 12; phase++) begin
         random_layout();
         calm    = (phase == 11);
         gap_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 20 : 50);
         if (phase == 3) begin
            hold_rsp = 1'b1;
            gap_pct  = 0;
         end
         repeat (105) random_item();
      end

      drain();
      $display("Ran %0d transactions over %0d pool layouts: %0d allocations granted, %0d refused,",
               sb.n_granted + sb.n_refused + sb.n_released + sb.n_unmatched, n_layouts,
               sb.n_granted, sb.n_refused);
      $display("%0d frees matched, %0d unmatched; %0d mismatches.",
               sb.n_released, sb.n_unmatched, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
